// ===== hw/rtl/smp_pkg.sv =====
// Shared types and constants for the symbolic mode parser.
// No dependencies; every other file of the block imports this package.
package smp_pkg;

  typedef logic [11:0] mode_t;
  typedef logic [2:0]  who_t;

  // Operator codes: none, '+', '-' and '='.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_SET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_ASSIGN = 2'd3
  } op_t;

  // Who set encoding: bit 2 is user, bit 1 is group, bit 0 is other.
  localparam who_t WHO_U   = 3'b100;
  localparam who_t WHO_G   = 3'b010;
  localparam who_t WHO_O   = 3'b001;
  localparam who_t WHO_ALL = 3'b111;

  localparam mode_t MASK_U      = 12'o4700;
  localparam mode_t MASK_G      = 12'o2070;
  localparam mode_t MASK_O      = 12'o0007;
  localparam mode_t BIT_SETUID  = 12'o4000;
  localparam mode_t BIT_SETGID  = 12'o2000;
  localparam mode_t BIT_STICKY  = 12'o1000;
  localparam mode_t MODE_MASK   = 12'o7777;

  // Character classes produced by the decoder.
  typedef struct packed {
    logic       is_who;
    who_t       who;
    logic       is_op;
    op_t        op;
    logic       is_perm;
    logic [2:0] perm_rwx;    // 4 for r, 2 for w, 1 for x, 0 otherwise
    logic       perm_suid;   // the 's' letter
    logic       perm_stky;   // the 't' letter
    logic       is_comma;
  } dec_t;

endpackage

// ===== hw/rtl/smp_if.sv =====
// Valid/ready channel interfaces for the symbolic mode parser.
// Depends on smp_pkg for the mode type.
interface smp_in_if import smp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  mode_t      old_mode;
  logic       last;

  modport source (output valid, ch, first, old_mode, last, input ready);
  modport sink   (input valid, ch, first, old_mode, last, output ready);
endinterface

interface smp_out_if import smp_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t new_mode;
  logic  bad_syntax;

  modport source (output valid, new_mode, bad_syntax, input ready);
  modport sink   (input valid, new_mode, bad_syntax, output ready);
endinterface

// ===== hw/rtl/symbolic_mode_parser_top.sv =====
// Symbolic permission mode parser: takes one character per item and, on the
// last character of a string, delivers the new 12-bit mode and a syntax flag.
// The block accepts one item per clock cycle while it is not stalled. An accepted
// item is held in the input register, where it is decoded and applied to the parse
// state, and its result, if any, is loaded into the result register when the item
// advances, so a result passes through the input and then the result register.
// Input and result registers stall only when a finished result waits in the
// result register and the next item would produce another.
// Depends on smp_pkg, smp_if, smp_decode and smp_state.
module symbolic_mode_parser_top import smp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  smp_in_if.sink           in_ch,
  smp_out_if.source        out_ch
);

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_first_r;
  mode_t      s1_old_r;
  logic       s1_last_r;

  logic       out_valid_r;
  mode_t      out_mode_r;
  logic       out_bad_r;

  dec_t       dec;
  mode_t      mode_nxt;
  logic       err_nxt;
  logic       s1_adv;
  logic       out_free;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  smp_decode u_decode (
    .ch  (s1_ch_r),
    .dec (dec)
  );

  smp_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .first    (s1_first_r),
    .old_mode (s1_old_r),
    .dec      (dec),
    .mode_nxt (mode_nxt),
    .err_nxt  (err_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_ch_r    <= in_ch.ch;
      s1_first_r <= in_ch.first;
      s1_old_r   <= in_ch.old_mode;
      s1_last_r  <= in_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_mode_r <= mode_nxt;
      out_bad_r  <= err_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_mode   = out_mode_r;
  assign out_ch.bad_syntax = out_bad_r;

endmodule

// ===== hw/rtl/smp_decode.sv =====
// Character classifier for the symbolic mode parser.
// Depends on smp_pkg for the decoded class struct.
module smp_decode import smp_pkg::*; (
  input  logic [7:0] ch,
  output dec_t       dec
);

  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  always_comb begin
    dec = '0;
    dec.op = OP_NONE;
    case (ch)
      CH_U:     begin dec.is_who = 1'b1; dec.who = WHO_U;   end
      CH_G:     begin dec.is_who = 1'b1; dec.who = WHO_G;   end
      CH_O:     begin dec.is_who = 1'b1; dec.who = WHO_O;   end
      CH_A:     begin dec.is_who = 1'b1; dec.who = WHO_ALL; end
      CH_PLUS:  begin dec.is_op = 1'b1; dec.op = OP_SET;    end
      CH_MINUS: begin dec.is_op = 1'b1; dec.op = OP_CLEAR;  end
      CH_EQ:    begin dec.is_op = 1'b1; dec.op = OP_ASSIGN; end
      CH_R:     begin dec.is_perm = 1'b1; dec.perm_rwx = 3'd4; end
      CH_W:     begin dec.is_perm = 1'b1; dec.perm_rwx = 3'd2; end
      CH_X:     begin dec.is_perm = 1'b1; dec.perm_rwx = 3'd1; end
      CH_S:     begin dec.is_perm = 1'b1; dec.perm_suid = 1'b1; end
      CH_T:     begin dec.is_perm = 1'b1; dec.perm_stky = 1'b1; end
      CH_COMMA: dec.is_comma = 1'b1;
      default:  dec = '0;
    endcase
  end

endmodule

// ===== hw/rtl/smp_state.sv =====
// Parse state registers and their update for one decoded character.
// Depends on smp_pkg for types, masks and operator codes.
module smp_state import smp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  logic  first,
  input  mode_t old_mode,
  input  dec_t  dec,
  output mode_t mode_nxt,
  output logic  err_nxt
);

  mode_t mode_r;
  who_t  who_r, who_nxt;
  logic  in_who_r, in_who_nxt;
  op_t   op_r, op_nxt;
  logic  err_r;

  function automatic mode_t who_mask(who_t w);
    mode_t m;
    m = '0;
    if (w[2]) m = m | MASK_U;
    if (w[1]) m = m | MASK_G;
    if (w[0]) m = m | MASK_O;
    return m;
  endfunction

  function automatic mode_t perm_bits(dec_t d, who_t w);
    mode_t p;
    p = '0;
    if (w[2]) p = p | {3'b000, d.perm_rwx, 6'b0};
    if (w[1]) p = p | {6'b0, d.perm_rwx, 3'b000};
    if (w[0]) p = p | {9'b0, d.perm_rwx};
    if (d.perm_suid && w[2]) p = p | BIT_SETUID;
    if (d.perm_suid && w[1]) p = p | BIT_SETGID;
    if (d.perm_stky) p = p | BIT_STICKY;
    return p;
  endfunction

  mode_t mode_e;
  who_t  who_e, who_op;
  logic  in_who_e;
  op_t   op_e;
  logic  err_e;
  mode_t pbits;

  always_comb begin
    // A first character restarts parsing from the old mode.
    mode_e   = first ? old_mode : mode_r;
    who_e    = first ? '0 : who_r;
    in_who_e = first ? 1'b1 : in_who_r;
    op_e     = first ? OP_NONE : op_r;
    err_e    = first ? 1'b0 : err_r;

    // An operator with an empty who set acts on all classes.
    who_op = (who_e == '0) ? WHO_ALL : who_e;
    pbits  = perm_bits(dec, who_e);

    mode_nxt   = mode_e;
    who_nxt    = who_e;
    in_who_nxt = in_who_e;
    op_nxt     = op_e;
    err_nxt    = err_e;

    if (dec.is_op && (in_who_e || !dec.is_perm)) begin
      who_nxt    = who_op;
      op_nxt     = dec.op;
      in_who_nxt = 1'b0;
      if (dec.op == OP_ASSIGN) mode_nxt = mode_e & ~who_mask(who_op);
    end

    if (in_who_e) begin
      if (dec.is_who) begin
        who_nxt = who_e | dec.who;
      end else if (!dec.is_op) begin
        err_nxt = 1'b1;
      end
    end else if (dec.is_perm) begin
      if (op_e == OP_CLEAR) begin
        mode_nxt = mode_e & ~pbits;
      end else if (op_e != OP_NONE) begin
        mode_nxt = mode_e | pbits;
      end
    end else if (dec.is_comma) begin
      in_who_nxt = 1'b1;
      who_nxt    = '0;
      op_nxt     = OP_NONE;
    end else if (dec.is_who) begin
      in_who_nxt = 1'b1;
      who_nxt    = dec.who;
      op_nxt     = OP_NONE;
    end else if (!dec.is_op) begin
      err_nxt = 1'b1;
    end
    mode_nxt = mode_nxt & MODE_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      who_r    <= '0;
      in_who_r <= 1'b1;
      op_r     <= OP_NONE;
      err_r    <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      who_r    <= who_nxt;
      in_who_r <= in_who_nxt;
      op_r     <= op_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
